>>> design/polargraph_cable_length_delta_assert.svh
// Assertion macros shared by the cable-length delta RTL.
// Relies on the including module having clk and active-low rst_n in scope.
`ifndef POLARGRAPH_CABLE_LENGTH_DELTA_ASSERT_SVH
`define POLARGRAPH_CABLE_LENGTH_DELTA_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define PGCL_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pgcl: same-cycle check failed");

// Next-cycle implication, checked outside reset
`define PGCL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pgcl: next-cycle check failed");

`endif

>>> design/pgcl_pkg.sv
// Shared types and constants for the polargraph cable-length delta block.
// No dependencies; used by the cable-length delta top level.
package pgcl_pkg;

    localparam int COORD_FIELD_W = 14;
    localparam int ANCHOR_W      = 14;
    localparam int LEN_W         = 15;
    localparam int DELTA_W       = 16;
    localparam int PEN_W         = 8;
    localparam int CFG_INDEX_W   = 2;
    localparam int CFG_DATA_W    = 15;

    localparam logic [LEN_W-1:0]    LEN_MAX          = 15'd32767;
    localparam logic [ANCHOR_W-1:0] ANCHOR_RESET     = 14'd5684;
    localparam logic [LEN_W-1:0]    HOME_LEFT_RESET  = 15'd2697;
    localparam logic [LEN_W-1:0]    HOME_RIGHT_RESET = 15'd4448;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_RIGHT_ANCHOR_X    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_HOME_LEFT_LENGTH  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_HOME_RIGHT_LENGTH = 2'd2;

    typedef struct packed {
        logic [COORD_FIELD_W-1:0] target_x;
        logic [COORD_FIELD_W-1:0] target_y;
        logic [PEN_W-1:0]         pen_level;
    } target_item_t;

    typedef struct packed {
        logic signed [DELTA_W-1:0] left_delta;
        logic signed [DELTA_W-1:0] right_delta;
        logic [PEN_W-1:0]          pen_out;
    } delta_item_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_ROOT,
        ST_HOLD
    } state_t;

endpackage

>>> design/pgcl_sqsum.sv
// Bit-serial sum of squares a*a + b*b, one multiplier bit per cycle.
// Standalone; instantiated by the cable-length delta top level.
module pgcl_sqsum #(
    parameter int XW = 14
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [XW-1:0]   a,
    input  logic [XW-1:0]   b,
    output logic [2*XW:0]   sum,
    output logic            done
);

    localparam int SW = 2 * XW + 1;
    localparam int CW = $clog2(XW + 1);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [XW-1:0] a_sh_reg, a_sh_next;
    logic [XW-1:0] b_sh_reg, b_sh_next;
    logic [SW-1:0] a_mc_reg, a_mc_next;
    logic [SW-1:0] b_mc_reg, b_mc_next;
    logic [SW-1:0] acc_reg, acc_next;

    // Add the shifted multiplicands selected by the low multiplier bits
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        a_sh_next = a_sh_reg;
        b_sh_next = b_sh_reg;
        a_mc_next = a_mc_reg;
        b_mc_next = b_mc_reg;
        acc_next  = acc_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(XW);
            a_sh_next = a;
            b_sh_next = b;
            a_mc_next = SW'(a);
            b_mc_next = SW'(b);
            acc_next  = '0;
        end
        else if (busy_reg)
        begin
            acc_next  = acc_reg + (a_sh_reg[0] ? a_mc_reg : '0)
                                + (b_sh_reg[0] ? b_mc_reg : '0);
            a_sh_next = a_sh_reg >> 1;
            b_sh_next = b_sh_reg >> 1;
            a_mc_next = a_mc_reg << 1;
            b_mc_next = b_mc_reg << 1;
            cnt_next  = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Advance the datapath shift registers
    always_ff @(posedge clk)
    begin
        a_sh_reg <= a_sh_next;
        b_sh_reg <= b_sh_next;
        a_mc_reg <= a_mc_next;
        b_mc_reg <= b_mc_next;
        acc_reg  <= acc_next;
    end

    assign sum  = acc_reg;
    assign done = done_reg;

endmodule

>>> design/pgcl_isqrt.sv
// Digit-by-digit floor square root, one root bit per cycle.
// Standalone; instantiated by the cable-length delta top level.
module pgcl_isqrt #(
    parameter int N = 15
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [2*N-2:0]    radicand,
    output logic [N-1:0]      root,
    output logic              done
);

    localparam int RADW = 2 * N;
    localparam int CW   = $clog2(N + 1);

    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic [RADW-1:0] rad_reg, rad_next;
    logic [N:0]      rem_reg, rem_next;
    logic [N-1:0]    root_reg, root_next;
    logic [N+2:0]    rem_sh;
    logic [N+2:0]    trial;
    logic [N+2:0]    diff;

    // Bring down two radicand bits and try the next root bit
    always_comb
    begin
        rem_sh    = {rem_reg, rad_reg[RADW-1 -: 2]};
        trial     = {1'b0, root_reg, 2'b01};
        diff      = rem_sh - trial;
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(N);
            rad_next  = RADW'(radicand);
            rem_next  = '0;
            root_next = '0;
        end
        else if (busy_reg)
        begin
            rad_next = rad_reg << 2;
            cnt_next = cnt_reg - CW'(1);
            if (rem_sh >= trial)
            begin
                rem_next  = diff[N:0];
                root_next = {root_reg[N-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_sh[N:0];
                root_next = {root_reg[N-2:0], 1'b0};
            end
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Advance the radicand, remainder and root registers
    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign root = root_reg;
    assign done = done_reg;

endmodule

>>> design/polargraph_cable_length_delta.sv
// Polargraph cable-length delta: one request carries a target pen point and a pen level and
// yields one result with the signed change of the left and right cable lengths,
// floor(sqrt(x^2+y^2)) and floor(sqrt((anchor-x)^2+y^2)), against the stored lengths, which
// are then replaced. The block works on one request at a time, with W-bit operands, where W
// is the larger of COORD_BITS and 14. After acceptance the bit-serial square-and-add units
// run, the roots are started, the bit-serial square-root units run, the block leaves the
// root phase and the output register is loaded; there is one unit of each kind per cable,
// running side by side. A finished result sits in an output register, so the next request
// can be taken once the result has moved there; a stalled, full output register holds the
// finished result back until the register is free. Register writes are taken only while no
// request is in progress. Writing a home length also loads it into the matching stored length.
// Depends on pgcl_pkg, pgcl_sqsum, pgcl_isqrt and the assertion macro header.
`include "polargraph_cable_length_delta_assert.svh"

module polargraph_cable_length_delta #(
    parameter int COORD_BITS = 14
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 target_valid,
    output logic                                 target_stall,
    input  pgcl_pkg::target_item_t               target,
    output logic                                 delta_valid,
    input  logic                                 delta_stall,
    output pgcl_pkg::delta_item_t                delta,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [pgcl_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [pgcl_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int XW = (COORD_BITS > pgcl_pkg::COORD_FIELD_W) ?
                        COORD_BITS : pgcl_pkg::COORD_FIELD_W;
    localparam int SW = 2 * XW + 1;
    localparam int RW = XW + 1;
    localparam logic [XW-1:0] COORD_MASK = XW'((64'd1 << COORD_BITS) - 64'd1);

    pgcl_pkg::state_t state_reg, state_next;

    logic [pgcl_pkg::ANCHOR_W-1:0] anchor_reg;
    logic [pgcl_pkg::LEN_W-1:0]    left_len_reg;
    logic [pgcl_pkg::LEN_W-1:0]    right_len_reg;
    logic [pgcl_pkg::PEN_W-1:0]    pen_reg;
    logic                          out_valid_reg;
    pgcl_pkg::delta_item_t         out_reg, out_next;

    logic          accept;
    logic          cfg_write;
    logic          sq_start;
    logic          rt_start;
    logic          load_out;
    logic [XW-1:0] x_in;
    logic [XW-1:0] y_in;
    logic [XW-1:0] anchor_w;
    logic [XW-1:0] rdx;
    logic [SW-1:0] l_sum;
    logic [SW-1:0] r_sum;
    logic          l_sq_done;
    logic          r_sq_done;
    logic [RW-1:0] l_root;
    logic [RW-1:0] r_root;
    logic          l_rt_done;
    logic          r_rt_done;
    logic [pgcl_pkg::LEN_W-1:0] new_left;
    logic [pgcl_pkg::LEN_W-1:0] new_right;

    assign target_stall = (state_reg != pgcl_pkg::ST_IDLE);
    assign accept       = target_valid & ~target_stall;
    assign cfg_ready    = (state_reg == pgcl_pkg::ST_IDLE);
    assign cfg_write    = cfg_valid & cfg_ready;

    // Mask coordinates and form the horizontal distance to the right anchor
    always_comb
    begin
        x_in     = XW'(target.target_x) & COORD_MASK;
        y_in     = XW'(target.target_y) & COORD_MASK;
        anchor_w = XW'(anchor_reg);
        rdx      = (anchor_w >= x_in) ? (anchor_w - x_in) : (x_in - anchor_w);
    end

    pgcl_sqsum #(.XW(XW)) u_left_sq (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sq_start),
        .a     (x_in),
        .b     (y_in),
        .sum   (l_sum),
        .done  (l_sq_done)
    );

    pgcl_sqsum #(.XW(XW)) u_right_sq (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sq_start),
        .a     (rdx),
        .b     (y_in),
        .sum   (r_sum),
        .done  (r_sq_done)
    );

    pgcl_isqrt #(.N(RW)) u_left_rt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (rt_start),
        .radicand (l_sum),
        .root     (l_root),
        .done     (l_rt_done)
    );

    pgcl_isqrt #(.N(RW)) u_right_rt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (rt_start),
        .radicand (r_sum),
        .root     (r_root),
        .done     (r_rt_done)
    );

    // Saturate the roots and form the result
    always_comb
    begin
        new_left  = (l_root > RW'(pgcl_pkg::LEN_MAX)) ? pgcl_pkg::LEN_MAX
                                                      : l_root[pgcl_pkg::LEN_W-1:0];
        new_right = (r_root > RW'(pgcl_pkg::LEN_MAX)) ? pgcl_pkg::LEN_MAX
                                                      : r_root[pgcl_pkg::LEN_W-1:0];
        out_next.left_delta  = signed'({1'b0, new_left} - {1'b0, left_len_reg});
        out_next.right_delta = signed'({1'b0, new_right} - {1'b0, right_len_reg});
        out_next.pen_out     = pen_reg;
    end

    // Sequence the square and root phases, then hand off to the output register
    always_comb
    begin
        state_next = state_reg;
        sq_start   = 1'b0;
        rt_start   = 1'b0;
        load_out   = 1'b0;
        unique case (state_reg)
            pgcl_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    sq_start   = 1'b1;
                    state_next = pgcl_pkg::ST_SQUARE;
                end
            end
            pgcl_pkg::ST_SQUARE:
            begin
                if (l_sq_done & r_sq_done)
                begin
                    rt_start   = 1'b1;
                    state_next = pgcl_pkg::ST_ROOT;
                end
            end
            pgcl_pkg::ST_ROOT:
            begin
                if (l_rt_done & r_rt_done)
                begin
                    state_next = pgcl_pkg::ST_HOLD;
                end
            end
            pgcl_pkg::ST_HOLD:
            begin
                if (!out_valid_reg || !delta_stall)
                begin
                    load_out   = 1'b1;
                    state_next = pgcl_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pgcl_pkg::ST_IDLE;
            end
        endcase
    end

    // Hold the state, configuration, stored lengths and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pgcl_pkg::ST_IDLE;
            anchor_reg    <= pgcl_pkg::ANCHOR_RESET;
            left_len_reg  <= pgcl_pkg::HOME_LEFT_RESET;
            right_len_reg <= pgcl_pkg::HOME_RIGHT_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_write)
            begin
                priority if (cfg_index == pgcl_pkg::CFG_RIGHT_ANCHOR_X)
                    anchor_reg <= cfg_data[pgcl_pkg::ANCHOR_W-1:0];
                else if (cfg_index == pgcl_pkg::CFG_HOME_LEFT_LENGTH)
                    left_len_reg <= cfg_data;
                else if (cfg_index == pgcl_pkg::CFG_HOME_RIGHT_LENGTH)
                    right_len_reg <= cfg_data;
                else
                    anchor_reg <= anchor_reg;
            end
            if (load_out)
            begin
                left_len_reg  <= new_left;
                right_len_reg <= new_right;
                out_valid_reg <= 1'b1;
            end
            else if (!delta_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Capture the pen level and the result payload
    always_ff @(posedge clk)
    begin
        if (accept)
            pen_reg <= target.pen_level;
        if (load_out)
            out_reg <= out_next;
    end

    assign delta_valid = out_valid_reg;
    assign delta       = out_reg;

    // Both cable lanes run in lockstep
    `PGCL_ASSERT_IMPLY(a_lanes_lockstep, l_rt_done || r_rt_done, l_rt_done && r_rt_done)
    // Root results arrive only while the root phase is active
    `PGCL_ASSERT_IMPLY(a_root_in_phase, l_rt_done, state_reg == pgcl_pkg::ST_ROOT)
    // An accepted request starts the square phase
    `PGCL_ASSERT_NEXT(a_accept_starts, accept, state_reg == pgcl_pkg::ST_SQUARE)
    // A finished result waits while the output register is full and stalled
    `PGCL_ASSERT_NEXT(a_hold_waits,
        state_reg == pgcl_pkg::ST_HOLD && out_valid_reg && delta_stall,
        state_reg == pgcl_pkg::ST_HOLD)

endmodule
